[hdl/ssmz_pkg.sv]
// shared types, constants and state encoding for the subsequence match zeroer
package ssmz_pkg;

    localparam int WORD_W          = 32;
    localparam int MAX_ARRAY_DEF   = 64;
    localparam int MAX_PATTERN_DEF = 16;

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_ARRAY   = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [WORD_W-1:0] value;
        logic                     last;
    } ssmz_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] value_res;
        logic                     last_res;
    } ssmz_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_ZERO,
        ST_OUT_RD,
        ST_OUT
    } ssmz_state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic rd_scan;
        logic k_inc;
        logic k_clr;
        logic next_start;
        logic wr_zero;
        logic rd_out;
        logic i_inc;
        logic done;
    } ssmz_cmd_t;

    typedef struct packed {
        logic skip;
        logic eq;
        logic k_last;
        logic start_last;
        logic i_last;
    } ssmz_stat_t;

endpackage

[hdl/subsequence_match_zeroer.sv]
// top level of the subsequence match zeroer
//
// loads a pattern of signed words (op 0) and then an array of signed words
// (op 1); the array beat marked last starts a scan of every start position
// in rising order, zeroing each window that matches the pattern against the
// current array contents, and then the whole array streams out with the
// final beat marked by last_res. the pattern is kept for later arrays and a
// pattern beat after a closed pattern starts a new one. beats beyond
// MAX_PATTERN or MAX_ARRAY are dropped, though their last mark still counts.
// the input is held off while a scan and its output run. after the array
// end beat comes a setup state, then each compared word is read and then
// compared, each zeroed word is written, and each output beat is read and
// then held until m_ready takes it. these steps are set by the single-port
// array memory with registered read, which serves the compare, the zeroing
// and the output in turn.
module subsequence_match_zeroer
    import ssmz_pkg::*;
#(
    parameter int MAX_ARRAY   = MAX_ARRAY_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    // input beats
    input  logic      s_valid,
    output logic      s_ready,
    input  ssmz_in_t  s_data,
    // result beats
    output logic      m_valid,
    input  logic      m_ready,
    output ssmz_out_t m_data
);

    ssmz_cmd_t  cmd;
    ssmz_stat_t stat;

    // sequencing of load, scan, zero and output phases
    ssmz_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_data  (s_data),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // memories, counters and the word compare
    ssmz_dp #(
        .MAX_ARRAY   (MAX_ARRAY),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

[hdl/ssmz_ctrl.sv]
// controller state machine for load, scan, zero and output sequencing
module ssmz_ctrl
    import ssmz_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  ssmz_in_t   s_data,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  ssmz_stat_t stat,
    output ssmz_cmd_t  cmd
);

    ssmz_state_t state_reg, state_next;
    logic        arr_end;

    assign arr_end = s_valid && (s_data.op == OP_ARRAY) && s_data.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (arr_end) state_next = ST_START;
            end
            ST_START: begin
                state_next = stat.skip ? ST_OUT_RD : ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (!stat.eq) begin
                    state_next = stat.start_last ? ST_OUT_RD : ST_SCAN_RD;
                end else if (stat.k_last) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_ZERO: begin
                if (stat.k_last) state_next = stat.start_last ? ST_OUT_RD : ST_SCAN_RD;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = stat.i_last ? ST_IDLE : ST_OUT_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                cmd.init = arr_end;
            end
            ST_START: begin
            end
            ST_SCAN_RD: begin
                cmd.rd_scan = 1'b1;
            end
            ST_SCAN_CMP: begin
                if (!stat.eq) begin
                    cmd.next_start = !stat.start_last;
                end else if (stat.k_last) begin
                    cmd.k_clr = 1'b1;
                end else begin
                    cmd.k_inc = 1'b1;
                end
            end
            ST_ZERO: begin
                cmd.wr_zero = 1'b1;
                if (stat.k_last) begin
                    cmd.next_start = !stat.start_last;
                end else begin
                    cmd.k_inc = 1'b1;
                end
            end
            ST_OUT_RD: begin
                cmd.rd_out = 1'b1;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.done  = stat.i_last;
                    cmd.i_inc = !stat.i_last;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[hdl/ssmz_dp.sv]
// datapath: pattern and array memories, counters, window compare
module ssmz_dp
    import ssmz_pkg::*;
#(
    parameter int MAX_ARRAY   = MAX_ARRAY_DEF,
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  ssmz_in_t   s_data,
    input  ssmz_cmd_t  cmd,
    output ssmz_stat_t stat,
    output ssmz_out_t  m_data
);

    localparam int AW   = (MAX_ARRAY > 1) ? $clog2(MAX_ARRAY) : 1;
    localparam int PW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int ACW  = $clog2(MAX_ARRAY + 1);
    localparam int PCW  = $clog2(MAX_PATTERN + 1);
    localparam int SUMW = ((ACW > PCW) ? ACW : PCW) + 1;

    logic signed [WORD_W-1:0] arr_mem [MAX_ARRAY];
    logic signed [WORD_W-1:0] pat_mem [MAX_PATTERN];

    logic [PCW-1:0] pat_cnt_reg, pat_cnt_next;
    logic           pat_closed_reg, pat_closed_next;
    logic [ACW-1:0] arr_cnt_reg, arr_cnt_next;
    logic [ACW-1:0] start_reg, start_next;
    logic [PW-1:0]  k_reg, k_next;
    logic [AW-1:0]  i_reg, i_next;

    logic signed [WORD_W-1:0] arr_q_reg;
    logic signed [WORD_W-1:0] pat_q_reg;

    logic [PCW-1:0]           pat_base;
    logic                     pat_wr;
    logic                     arr_load;
    logic [SUMW-1:0]          scan_sum;
    logic [AW-1:0]            scan_addr;
    logic                     arr_wr;
    logic [AW-1:0]            arr_wr_addr;
    logic signed [WORD_W-1:0] arr_wr_data;

    // pattern loading: a closed pattern restarts at zero
    assign pat_base = pat_closed_reg ? '0 : pat_cnt_reg;
    assign pat_wr   = cmd.load && (s_data.op == OP_PATTERN)
                      && (pat_base < PCW'(MAX_PATTERN));
    assign arr_load = cmd.load && (s_data.op == OP_ARRAY)
                      && (arr_cnt_reg < ACW'(MAX_ARRAY));

    assign scan_sum  = SUMW'(start_reg) + SUMW'(k_reg);
    assign scan_addr = scan_sum[AW-1:0];

    assign arr_wr      = arr_load || cmd.wr_zero;
    assign arr_wr_addr = cmd.wr_zero ? scan_addr : arr_cnt_reg[AW-1:0];
    assign arr_wr_data = cmd.wr_zero ? '0 : s_data.value;

    always_comb begin
        pat_cnt_next    = pat_cnt_reg;
        pat_closed_next = pat_closed_reg;
        arr_cnt_next    = arr_cnt_reg;
        start_next      = start_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        if (cmd.load && (s_data.op == OP_PATTERN)) begin
            pat_cnt_next    = pat_wr ? pat_base + PCW'(1) : pat_base;
            pat_closed_next = s_data.last;
        end
        if (arr_load) arr_cnt_next = arr_cnt_reg + ACW'(1);
        if (cmd.done) arr_cnt_next = '0;
        if (cmd.init) begin
            start_next = '0;
            k_next     = '0;
            i_next     = '0;
        end
        if (cmd.k_inc) k_next = k_reg + PW'(1);
        if (cmd.k_clr) k_next = '0;
        if (cmd.next_start) begin
            start_next = start_reg + ACW'(1);
            k_next     = '0;
        end
        if (cmd.i_inc) i_next = i_reg + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_cnt_reg    <= '0;
            pat_closed_reg <= 1'b0;
            arr_cnt_reg    <= '0;
            start_reg      <= '0;
            k_reg          <= '0;
            i_reg          <= '0;
        end else begin
            pat_cnt_reg    <= pat_cnt_next;
            pat_closed_reg <= pat_closed_next;
            arr_cnt_reg    <= arr_cnt_next;
            start_reg      <= start_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
        end
    end

    // memories with registered reads
    always_ff @(posedge aclk) begin
        if (pat_wr) pat_mem[pat_base[PW-1:0]] <= s_data.value;
        if (cmd.rd_scan) pat_q_reg <= pat_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (arr_wr) arr_mem[arr_wr_addr] <= arr_wr_data;
        if (cmd.rd_scan) begin
            arr_q_reg <= arr_mem[scan_addr];
        end else if (cmd.rd_out) begin
            arr_q_reg <= arr_mem[i_reg];
        end
    end

    assign stat.skip       = (pat_cnt_reg == '0) || (SUMW'(pat_cnt_reg) > SUMW'(arr_cnt_reg));
    assign stat.eq         = (arr_q_reg == pat_q_reg);
    assign stat.k_last     = (SUMW'(k_reg) + SUMW'(1)) == SUMW'(pat_cnt_reg);
    assign stat.start_last = (SUMW'(start_reg) + SUMW'(pat_cnt_reg)) == SUMW'(arr_cnt_reg);
    assign stat.i_last     = (SUMW'(i_reg) + SUMW'(1)) == SUMW'(arr_cnt_reg);

    assign m_data.value_res = arr_q_reg;
    assign m_data.last_res  = stat.i_last;

endmodule
